// ===== hw/rtl/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dsfe_pkg
// Shared types, constants and the CRC-16/ARC byte update for the DLE/STX
// frame encoder.
// ----------------------------------------------------------------------------
package dsfe_pkg;

	localparam logic [7:0] DLE = 8'h10;
	localparam logic [7:0] STX = 8'h02;
	localparam logic [7:0] ETX = 8'h03;

	// 0x8005 bit-reversed, for the shift-right (reflected) form
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	localparam logic [3:0] BOARD_SEL_MIN = 4'd1;
	localparam logic [3:0] BOARD_SEL_MAX = 4'd8;

	// One classified frame: the four payload bytes, declared in reverse send order
	typedef struct packed {
		logic [7:0] crc_lo;
		logic [7:0] crc_hi;
		logic [7:0] cmd;
		logic [7:0] mask;
	} payload_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SOF_STX,
		ST_PAY,
		ST_EOF_DLE,
		ST_EOF_ETX
	} back_state_t;

	// CRC-16/ARC update with one byte, reflected
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/dsfe_front.sv =====
// ----------------------------------------------------------------------------
// dsfe_front
// Accepts command bytes, builds the payload (mask, command, CRC) in two
// CRC byte steps and pushes it into the frame queue.
// ----------------------------------------------------------------------------
module dsfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	output logic                push,
	output dsfe_pkg::payload_t  push_data,
	input  logic                q_full
);

	logic [3:0]  board_sel_q;
	logic        v_s1_q;
	logic [7:0]  cmd_s1;
	logic [7:0]  mask_s1;
	logic [15:0] crc1_s1;
	logic [7:0]  mask_d;
	logic [2:0]  bit_sel;
	logic [15:0] crc2;

	// board number register, clamped to 1..8 on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_sel_q <= dsfe_pkg::BOARD_SEL_MIN;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data < dsfe_pkg::BOARD_SEL_MIN) begin
				board_sel_q <= dsfe_pkg::BOARD_SEL_MIN;
			end else if (cfg_wr_data > dsfe_pkg::BOARD_SEL_MAX) begin
				board_sel_q <= dsfe_pkg::BOARD_SEL_MAX;
			end else begin
				board_sel_q <= cfg_wr_data;
			end
		end
	end

	assign bit_sel  = 3'(board_sel_q - 4'd1);
	assign mask_d   = 8'h01 << bit_sel;
	assign s_tready = !v_s1_q || !q_full;
	assign push     = v_s1_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (s_tready) begin
			v_s1_q <= s_tvalid;
		end
	end

	// first CRC byte (mask) in stage 1
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tdata;
			mask_s1 <= mask_d;
			crc1_s1 <= dsfe_pkg::crc_byte(16'h0000, mask_d);
		end
	end

	// second CRC byte (command) on the way into the queue
	assign crc2 = dsfe_pkg::crc_byte(crc1_s1, cmd_s1);

	always_comb begin
		push_data.mask   = mask_s1;
		push_data.cmd    = cmd_s1;
		push_data.crc_hi = crc2[15:8];
		push_data.crc_lo = crc2[7:0];
	end

endmodule

// ===== hw/rtl/dsfe_queue.sv =====
// ----------------------------------------------------------------------------
// dsfe_queue
// Small FIFO of classified payloads between front and back.
// ----------------------------------------------------------------------------
module dsfe_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dsfe_pkg::payload_t  push_data,
	output logic                full,
	input  logic                pop,
	output dsfe_pkg::payload_t  pop_data,
	output logic                empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dsfe_pkg::payload_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/dsfe_back.sv =====
// ----------------------------------------------------------------------------
// dsfe_back
// Serializes one payload into a DLE STX ... DLE ETX frame with DLE
// stuffing, one byte per cycle while m_tready is high, through a registered output.
// ----------------------------------------------------------------------------
module dsfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  dsfe_pkg::payload_t  q_data,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);

	dsfe_pkg::back_state_t state_q, state_d;
	dsfe_pkg::payload_t    frame_q;
	logic [1:0]  idx_q, idx_d;
	logic        dup_q, dup_d;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;
	logic        emit;
	logic        load;
	logic [7:0]  byte_d;
	logic        last_d;
	logic [7:0]  pay_byte;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// output slot free or being drained this cycle
	assign emit = !out_valid_q || m_tready;

	always_comb begin
		case (idx_q)
			2'd0:    pay_byte = frame_q.mask;
			2'd1:    pay_byte = frame_q.cmd;
			2'd2:    pay_byte = frame_q.crc_hi;
			default: pay_byte = frame_q.crc_lo;
		endcase
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		dup_d   = dup_q;
		byte_d  = dsfe_pkg::DLE;
		last_d  = 1'b0;
		load    = 1'b0;
		pop     = 1'b0;
		if (emit) begin
			case (state_q)
				dsfe_pkg::ST_IDLE: begin
					if (!q_empty) begin
						pop     = 1'b1;
						load    = 1'b1;
						state_d = dsfe_pkg::ST_SOF_STX;
					end
				end
				dsfe_pkg::ST_SOF_STX: begin
					byte_d  = dsfe_pkg::STX;
					idx_d   = 2'd0;
					dup_d   = 1'b0;
					state_d = dsfe_pkg::ST_PAY;
				end
				dsfe_pkg::ST_PAY: begin
					if (pay_byte == dsfe_pkg::DLE && !dup_q) begin
						// escape: extra DLE first, same byte again next
						dup_d = 1'b1;
					end else begin
						byte_d = pay_byte;
						dup_d  = 1'b0;
						idx_d  = idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_d = dsfe_pkg::ST_EOF_DLE;
						end
					end
				end
				dsfe_pkg::ST_EOF_DLE: begin
					state_d = dsfe_pkg::ST_EOF_ETX;
				end
				dsfe_pkg::ST_EOF_ETX: begin
					byte_d  = dsfe_pkg::ETX;
					last_d  = 1'b1;
					state_d = dsfe_pkg::ST_IDLE;
				end
				default: begin
					state_d = dsfe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsfe_pkg::ST_IDLE;
			idx_q       <= 2'd0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dup_q   <= dup_d;
			if (emit) begin
				out_valid_q <= (state_q != dsfe_pkg::ST_IDLE) || !q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= q_data;
		end
		if (emit) begin
			out_data_q <= byte_d;
			out_last_q <= last_d;
		end
	end

endmodule

// ===== hw/rtl/dle_stx_frame_encoder_crc16_top.sv =====
// ----------------------------------------------------------------------------
// dle_stx_frame_encoder_crc16_top
// DLE/STX frame encoder with CRC-16/ARC, streaming in and out.
// ----------------------------------------------------------------------------
// Each command byte accepted on the s_ side becomes one frame on the m_ side,
// one byte per transaction: DLE STX, the destination mask (bit board number
// minus one), the command, the CRC-16/ARC of mask and command (high byte
// first), then DLE ETX, with m_tlast high on the ETX. Any payload byte equal
// to DLE 0x10 goes out twice. A frame is 8 to 12 bytes, and the back end
// byte serializer sends one byte per clock while m_tready is high; frames
// follow each other back to back. The front end computes the CRC in two
// byte steps (one in its input stage, one on the way into the payload
// queue), so with an idle back end a command passes the stage-1 register,
// the queue and the output register before the first frame byte is valid
// on m_. The queue of QUEUE_DEPTH payloads lets further commands be taken
// while a frame is still being sent. The board number is written through
// cfg_wr_en / cfg_wr_data; values are clamped to 1..8, reset value 1.
// Write it only while the encoder is idle.
// ----------------------------------------------------------------------------
module dle_stx_frame_encoder_crc16_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: board number
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	// command input
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] command_byte
	// frame output
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] frame_byte
	output logic       m_tlast    // last_byte (ETX)
);

	dsfe_pkg::payload_t push_data;
	dsfe_pkg::payload_t pop_data;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// front: board number register, mask and CRC
	dsfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	// payload queue decouples classification from serialization
	dsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// back: framing, DLE stuffing, output register
	dsfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
